>>> hw/rtl/cisc_pkg.sv
package cisc_pkg;

  localparam int unsigned MaxPatLen = 16;
  localparam int unsigned WinIdxW   = (MaxPatLen > 1) ? $clog2(MaxPatLen) : 1;
  localparam int unsigned LenW      = 5;
  localparam int unsigned PosW      = 32;
  localparam int unsigned CharW     = 8;
  localparam int unsigned PatBytes  = 16;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [CfgIdxW-1:0] CfgPatLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPatHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPatLen  = 2'd2;

  localparam logic [CharW-1:0] UpperFirst = 8'h41;
  localparam logic [CharW-1:0] UpperLast  = 8'h5A;
  localparam logic [CharW-1:0] CaseOffset = 8'd32;

  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic [PosW-1:0]  pos;
    logic             last;
  } item_t;

  typedef struct packed {
    logic             found;
    logic [PosW-1:0]  start;
    logic [PosW-1:0]  total;
    logic             done;
  } result_t;

  function automatic logic [CharW-1:0] fold_char(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    r = c;
    if (c inside {[UpperFirst:UpperLast]}) begin
      r = c + CaseOffset;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/case_insensitive_substring_counter.sv
// Streaming case-insensitive substring counter. One text byte is taken per
// beat and one result comes back per byte, in order, at a sustained rate of
// one byte per clock cycle while the output side does not stall. The front
// folds each accepted byte, tags it with its position and pushes it into a
// two-entry queue; the back pops it, shifts it into a 16-byte window,
// compares the whole window against the pattern combinationally and
// registers the result. Input stall rises only when the queue is full, which happens
// only while the output side stalls. The pattern registers and the length are
// written through the configuration channel, which is always ready; write
// them only while no bytes are in flight. Index 0 holds pattern bytes 0 to 7,
// index 1 bytes 8 to 15, index 2 the length (lengths above 16 act as 16,
// zero never matches); other indexes are ignored. A beat with end_of_text
// set reports its result and then clears the window, position and count.
module case_insensitive_substring_counter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cisc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cisc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    text_char_i,
  input  logic                          end_of_text_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          match_found_o,
  output logic [31:0]                   match_start_o,
  output logic [31:0]                   match_total_o,
  output logic                          text_done_o
);
  import cisc_pkg::*;

  logic [CfgDataW-1:0] pat_lo_q;
  logic [CfgDataW-1:0] pat_hi_q;
  logic [LenW-1:0]     pat_len_q;

  logic    push;
  item_t   push_item;
  logic    q_full;
  logic    q_empty;
  logic    pop;
  item_t   pop_item;
  result_t result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
      pat_len_q <= LenW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgPatLow:  pat_lo_q  <= cfg_data_i;
        CfgPatHigh: pat_hi_q  <= cfg_data_i;
        CfgPatLen:  pat_len_q <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  cisc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .text_char_i   (text_char_i),
    .end_of_text_i (end_of_text_i),
    .in_valid_i    (in_valid_i),
    .queue_full_i  (q_full),
    .in_stall_o    (in_stall_o),
    .push_o        (push),
    .push_item_o   (push_item)
  );

  cisc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .pop_item_o  (pop_item)
  );

  cisc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pattern_i   ({pat_hi_q, pat_lo_q}),
    .pat_len_i   (pat_len_q),
    .empty_i     (q_empty),
    .item_i      (pop_item),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .result_o    (result)
  );

  assign match_found_o = result.found;
  assign match_start_o = result.start;
  assign match_total_o = result.total;
  assign text_done_o   = result.done;

endmodule

>>> hw/rtl/cisc_front.sv
module cisc_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [7:0]             text_char_i,
  input  logic                   end_of_text_i,
  input  logic                   in_valid_i,
  input  logic                   queue_full_i,
  output logic                   in_stall_o,
  output logic                   push_o,
  output cisc_pkg::item_t        push_item_o
);
  import cisc_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;

  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i & ~queue_full_i;

  always_comb begin
    push_item_o.ch   = fold_char(text_char_i);
    push_item_o.pos  = pos_q;
    push_item_o.last = end_of_text_i;
  end

  always_comb begin
    pos_d = pos_q;
    if (push_o) begin
      if (end_of_text_i) begin
        pos_d = '0;
      end else if (pos_q != PosMax) begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

>>> hw/rtl/cisc_fifo.sv
module cisc_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cisc_pkg::item_t  push_item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output cisc_pkg::item_t  pop_item_o
);
  import cisc_pkg::*;

  item_t      slot_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_item_o = slot_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_item_i;
    end
  end

endmodule

>>> hw/rtl/cisc_back.sv
module cisc_back (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [cisc_pkg::PatBytes*8-1:0]       pattern_i,
  input  logic [cisc_pkg::LenW-1:0]             pat_len_i,
  input  logic                                  empty_i,
  input  cisc_pkg::item_t                       item_i,
  output logic                                  pop_o,
  input  logic                                  out_stall_i,
  output logic                                  out_valid_o,
  output cisc_pkg::result_t                     result_o
);
  import cisc_pkg::*;

  logic [CharW-1:0] win_q   [MaxPatLen];
  logic [CharW-1:0] win_new [MaxPatLen];
  logic [PosW-1:0]  cnt_q, cnt_d;
  logic             valid_q;
  result_t          res_q, res_d;
  logic [LenW-1:0]  len;
  logic [LenW-1:0]  len_m1;
  logic [MaxPatLen-1:0] eq;
  logic             pos_ok;
  logic             found;
  logic [PosW-1:0]  cnt_new;

  assign pop_o       = ~empty_i & (~valid_q | ~out_stall_i);
  assign out_valid_o = valid_q;
  assign result_o    = res_q;

  assign len    = (pat_len_i > LenW'(MaxPatLen)) ? LenW'(MaxPatLen) : pat_len_i;
  assign len_m1 = len - LenW'(1);
  assign pos_ok = item_i.pos >= PosW'(len_m1);

  always_comb begin
    win_new[0] = item_i.ch;
    for (int k = 1; k < MaxPatLen; k++) begin
      win_new[k] = win_q[k-1];
    end
  end

  always_comb begin
    logic [LenW-1:0] sel;
    for (int j = 0; j < MaxPatLen; j++) begin
      sel   = len_m1 - LenW'(j);
      eq[j] = (LenW'(j) >= len) ||
              (win_new[sel[WinIdxW-1:0]] == fold_char(pattern_i[j*8 +: 8]));
    end
  end

  assign found = (len != '0) & pos_ok & (&eq);

  always_comb begin
    cnt_new = cnt_q;
    if (found && cnt_q != PosMax) begin
      cnt_new = cnt_q + PosW'(1);
    end
    cnt_d       = item_i.last ? '0 : cnt_new;
    res_d.found = found;
    res_d.start = found ? (item_i.pos - PosW'(len_m1)) : '0;
    res_d.total = cnt_new;
    res_d.done  = item_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
      for (int k = 0; k < MaxPatLen; k++) begin
        win_q[k] <= '0;
      end
    end else begin
      if (pop_o) begin
        valid_q <= 1'b1;
        cnt_q   <= cnt_d;
        for (int k = 0; k < MaxPatLen; k++) begin
          win_q[k] <= item_i.last ? '0 : win_new[k];
        end
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

endmodule

>>> tb/sv/tb_case_insensitive_substring_counter.sv
`timescale 1ns / 1ps

module tb_case_insensitive_substring_counter;

  localparam int CycleLimit = 400000;
  localparam int ItemTarget = 1150;
  localparam int HoldCycles = 40;
  localparam int NRows      = 18;

  localparam logic [cisc_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;

  typedef enum logic [1:0] {RowWrite, RowByte, RowTyped} row_kind_e;

  typedef struct packed {
    row_kind_e                    kind;
    logic [cisc_pkg::CfgIdxW-1:0] idx;
    logic [63:0]                  data;
    logic [7:0]                   ch;
    logic                         eot;
    logic [4:0]                   reps;
    cisc_pkg::result_t            want;
  } step_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  text_char_i;
  logic        end_of_text_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        match_found_o;
  logic [31:0] match_start_o;
  logic [31:0] match_total_o;
  logic        text_done_o;

  case_insensitive_substring_counter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .text_char_i   (text_char_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .match_found_o (match_found_o),
    .match_start_o (match_start_o),
    .match_total_o (match_total_o),
    .text_done_o   (text_done_o)
  );

  // scanner state and configuration as the testbench sees it
  logic [63:0] pat_lo = '0;
  logic [63:0] pat_hi = '0;
  logic [4:0]  pat_len = 5'd1;
  logic [7:0]  win_bytes [16];
  logic [31:0] byte_pos = '0;
  logic [31:0] hit_count = '0;

  cisc_pkg::result_t match_reports_q [$];

  int  fails = 0;
  int  cycles = 0;
  int  bytes_sent = 0;
  int  texts_done = 0;
  int  matches_seen = 0;
  int  reg_writes = 0;
  int  stall_cycles = 0;
  bit  no_gaps = 0;
  bit  hold_req = 0;
  int  hold_cnt = 0;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic logic [7:0] lower(input logic [7:0] c);
    if (c >= cisc_pkg::UpperFirst && c <= cisc_pkg::UpperLast) begin
      return c + 8'd32;
    end
    return c;
  endfunction

  function automatic logic [7:0] pat_byte(input int j);
    return (j < 8) ? pat_lo[j*8 +: 8] : pat_hi[(j-8)*8 +: 8];
  endfunction

  function automatic cisc_pkg::result_t scan_byte(input logic [7:0] ch, input logic eot);
    cisc_pkg::result_t r;
    int len;
    len = (pat_len > 5'd16) ? 16 : int'(pat_len);
    for (int i = 15; i > 0; i--) win_bytes[i] = win_bytes[i-1];
    win_bytes[0] = lower(ch);
    r = '0;
    if (len != 0 && byte_pos >= 32'(len - 1)) begin
      r.found = 1'b1;
      for (int j = 0; j < len; j++) begin
        if (win_bytes[len-1-j] != lower(pat_byte(j))) r.found = 1'b0;
      end
      if (r.found) r.start = byte_pos - 32'(len - 1);
    end
    if (r.found && hit_count != '1) hit_count++;
    if (byte_pos != '1) byte_pos++;
    r.total = hit_count;
    r.done  = eot;
    if (eot) begin
      foreach (win_bytes[i]) win_bytes[i] = '0;
      byte_pos  = '0;
      hit_count = '0;
    end
    return r;
  endfunction

  function automatic logic [7:0] rand_char();
    case ($urandom_range(0, 7))
      0, 1, 2: return (8'h61 + 8'($urandom_range(0, 1))) ^ (8'($urandom_range(0, 1)) << 5);
      3: begin
        case ($urandom_range(0, 3))
          0: return 8'h40;
          1: return 8'h5B;
          2: return 8'h60;
          default: return 8'h7B;
        endcase
      end
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic logic [63:0] pick_pattern();
    logic [63:0] w;
    if ($urandom_range(0, 4) == 0) return {$urandom, $urandom};
    for (int i = 0; i < 8; i++) w[i*8 +: 8] = rand_char();
    return w;
  endfunction

  function automatic logic [4:0] pick_len();
    case ($urandom_range(0, 11))
      0: return 5'd0;
      1: return 5'd16;
      2: return 5'($urandom_range(17, 31));
      3: return 5'($urandom_range(8, 15));
      default: return 5'($urandom_range(1, 5));
    endcase
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      cisc_pkg::CfgPatLow:  pat_lo = data;
      cisc_pkg::CfgPatHigh: pat_hi = data;
      cisc_pkg::CfgPatLen:  pat_len = data[4:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] ch, input logic eot, input logic typed,
                           input cisc_pkg::result_t want);
    cisc_pkg::result_t r;
    @(negedge clk_i);
    while (!no_gaps && $urandom_range(0, 99) < 26) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    text_char_i   <= ch;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (in_stall_o);
    r = scan_byte(ch, eot);
    match_reports_q.push_back(typed ? want : r);
    bytes_sent++;
  endtask

  task automatic feed(input logic [7:0] ch);
    send_byte(ch, $urandom_range(0, 39) == 0, 1'b0, '0);
  endtask

  // wait until every byte in flight has reported
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (match_reports_q.size() != 0) @(posedge clk_i);
  endtask

  // output side: random stall, plus a long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cnt > 0) begin
        out_stall_i <= 1'b1;
        hold_cnt--;
      end else if (hold_req) begin
        hold_req = 0;
        hold_cnt = HoldCycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !no_gaps && ($urandom_range(0, 99) < 26);
      end
    end
  end

  always @(posedge clk_i) begin
    cisc_pkg::result_t want;
    if (rst_ni && in_valid_i && in_stall_o) stall_cycles++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (match_reports_q.size() == 0) begin
        $error("result beat with nothing expected");
        fails++;
      end else begin
        want = match_reports_q.pop_front();
        if (match_found_o !== want.found) begin
          $error("match_found: expected %0d, got %0d", want.found, match_found_o);
          fails++;
        end
        if (match_start_o !== want.start) begin
          $error("match_start: expected %0d, got %0d", want.start, match_start_o);
          fails++;
        end
        if (match_total_o !== want.total) begin
          $error("match_total: expected %0d, got %0d", want.total, match_total_o);
          fails++;
        end
        if (text_done_o !== want.done) begin
          $error("text_done: expected %0d, got %0d", want.done, text_done_o);
          fails++;
        end
        if (want.found) matches_seen++;
        if (want.done) texts_done++;
      end
    end
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_case_insensitive_substring_counter NOT OK");
    $finish;
  end

  initial begin
    step_row_t script [NRows];
    logic [7:0] c;
    int n, eff, broken, phase;

    script = '{
      '{RowTyped, 2'd0, 64'd0, 8'h78, 1'b0, 5'd1, '{1'b0, 32'd0, 32'd0, 1'b0}},
      '{RowTyped, 2'd0, 64'd0, 8'hFF, 1'b1, 5'd1, '{1'b0, 32'd0, 32'd0, 1'b1}},
      '{RowWrite, cisc_pkg::CfgPatLen, 64'd0, 8'h00, 1'b0, 5'd0, '0},
      '{RowTyped, 2'd0, 64'd0, 8'h01, 1'b1, 5'd1, '{1'b0, 32'd0, 32'd0, 1'b1}},
      '{RowWrite, cisc_pkg::CfgPatLow, 64'h6241, 8'h00, 1'b0, 5'd0, '0},
      '{RowWrite, cisc_pkg::CfgPatLen, 64'd2, 8'h00, 1'b0, 5'd0, '0},
      '{RowWrite, CfgUnused, 64'd0, 8'h00, 1'b0, 5'd0, '0},
      '{RowTyped, 2'd0, 64'd0, 8'h61, 1'b0, 5'd1, '{1'b0, 32'd0, 32'd0, 1'b0}},
      '{RowTyped, 2'd0, 64'd0, 8'h42, 1'b0, 5'd1, '{1'b1, 32'd0, 32'd1, 1'b0}},
      '{RowByte, 2'd0, 64'd0, 8'h41, 1'b0, 5'd1, '0},
      '{RowByte, 2'd0, 64'd0, 8'h62, 1'b0, 5'd1, '0},
      '{RowByte, 2'd0, 64'd0, 8'h40, 1'b1, 5'd1, '0},
      '{RowWrite, cisc_pkg::CfgPatLow, 64'h5A5A5A5A5A5A5A5A, 8'h00, 1'b0, 5'd0, '0},
      '{RowWrite, cisc_pkg::CfgPatHigh, 64'h7A7A7A7A7A7A7A7A, 8'h00, 1'b0, 5'd0, '0},
      '{RowWrite, cisc_pkg::CfgPatLen, 64'd31, 8'h00, 1'b0, 5'd0, '0},
      '{RowByte, 2'd0, 64'd0, 8'h7A, 1'b0, 5'd1, '0},
      '{RowByte, 2'd0, 64'd0, 8'h5A, 1'b0, 5'd15, '0},
      '{RowByte, 2'd0, 64'd0, 8'h7A, 1'b1, 5'd1, '0}
    };

    foreach (win_bytes[i]) win_bytes[i] = '0;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    text_char_i   = 8'h01;
    end_of_text_i = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == RowWrite) begin
        settle();
        write_reg(script[i].idx, script[i].data);
      end else begin
        repeat (script[i].reps) begin
          send_byte(script[i].ch, script[i].eot, script[i].kind == RowTyped, script[i].want);
        end
      end
    end

    phase = 0;
    while (bytes_sent < ItemTarget) begin
      settle();
      if ($urandom_range(0, 2) != 0) write_reg(cisc_pkg::CfgPatLow, pick_pattern());
      if ($urandom_range(0, 2) != 0) write_reg(cisc_pkg::CfgPatHigh, pick_pattern());
      if (phase < 2 || $urandom_range(0, 2) != 0) write_reg(cisc_pkg::CfgPatLen, 64'(pick_len()));
      if ($urandom_range(0, 9) == 0) write_reg(CfgUnused, {$urandom, $urandom});
      no_gaps = (phase >= 7 && phase <= 9);
      if (phase == 4 || phase == 14) hold_req = 1;
      n = $urandom_range(20, 60);
      while (n > 0) begin
        eff = (pat_len > 5'd16) ? 16 : int'(pat_len);
        if (eff != 0 && $urandom_range(0, 9) < 5) begin
          // a copy of the pattern in random case, sometimes with one byte spoiled
          broken = ($urandom_range(0, 4) == 0) ? $urandom_range(0, eff - 1) : -1;
          for (int j = 0; j < eff; j++) begin
            c = pat_byte(j);
            if (j == broken || c == 8'h00) begin
              c = rand_char();
            end else if (lower(c) >= 8'h61 && lower(c) <= 8'h7A) begin
              c = lower(c) ^ (8'($urandom_range(0, 1)) << 5);
            end
            feed(c);
          end
          n -= eff;
        end else begin
          feed(rand_char());
          n--;
        end
      end
      phase++;
    end

    settle();
    no_gaps = 0;
    repeat (4) @(posedge clk_i);
    $display("scanned %0d bytes in %0d finished texts, %0d matches, %0d register writes",
             bytes_sent, texts_done, matches_seen, reg_writes);
    $display("input stalled for %0d cycles while the output side held off", stall_cycles);
    if (fails == 0) begin
      $display("tb_case_insensitive_substring_counter OK");
    end else begin
      $display("tb_case_insensitive_substring_counter NOT OK");
    end
    $finish;
  end

endmodule
